// ----- src/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg: motor pattern sequencer shared definitions
// Item types, sequence state, codes, sizing constants and pattern tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  // sequence sizing
  localparam int unsigned FIXED_STEPS      = 40;
  localparam int unsigned BURST_TABLE_SIZE = 20;
  localparam int unsigned PATTERN_REPEATS  = 5;
  localparam int unsigned RAMP_STEPS       = 12;

  // fixed table lengths
  localparam int unsigned FIX_TABLE_LEN = 40;
  localparam int unsigned BURST_ROM_LEN = 20;
  localparam int unsigned PAT_LEN       = 4;

  // timing and duty
  localparam int unsigned BURST_MS      = 6000;
  localparam int unsigned BURST_STEP_MS = BURST_MS / RAMP_STEPS;
  localparam int unsigned PAUSE_MS      = 2000;
  localparam int unsigned PAT_DUTY      = 70;
  localparam int unsigned RAMP_BASE     = 60;
  localparam int unsigned RAMP_SPAN     = 40;
  localparam int unsigned RAMP_MAX      = RAMP_STEPS - 1;
  localparam int unsigned DUTY_MAX      = 100;
  localparam int unsigned DUTY_MIN      = 50;
  localparam int unsigned SPEED_RESET   = 50;

  // battery boost
  localparam int unsigned VMIN_MV     = 3500;
  localparam int unsigned VMAX_MV     = 4200;
  localparam int unsigned VSPAN_MV    = VMAX_MV - VMIN_MV;
  localparam int unsigned BOOST_MAX   = 20;
  localparam int unsigned BOOST_SHIFT = 15;
  // rounded-up reciprocal: exact floor for spans up to 700 mV
  localparam int unsigned BOOST_RECIP =
      ((1 << BOOST_SHIFT) * BOOST_MAX + VSPAN_MV - 1) / VSPAN_MV;

  // ramp duty reciprocal (rounded up, exact for numerators up to 600)
  localparam int unsigned RAMP_SHIFT = 16;
  localparam int unsigned RAMP_RECIP = ((1 << RAMP_SHIFT) + RAMP_MAX - 1) / RAMP_MAX;

  // seed reduction reciprocal (rounded down, one correction step)
  localparam int unsigned SEED_SHIFT = 12;
  localparam int unsigned SEED_RECIP = (1 << SEED_SHIFT) / BURST_TABLE_SIZE;

  // seed generator
  localparam int unsigned SEED_MUL = 13;
  localparam int unsigned SEED_ADD = 7;

  // configuration register indexes
  localparam logic [1:0] REG_WORK_MODE = 2'd0;
  localparam logic [1:0] REG_SPEED     = 2'd1;

  typedef enum logic [1:0] {
    KIND_EXPIRY = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    PH_PATTERN = 2'd0,
    PH_BURST   = 2'd1,
    PH_PAUSE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        external_power;
    logic [12:0] battery_mv;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic [6:0]  duty_pct;
    logic [11:0] delay_ms;
    logic        timer_armed;
    logic        running;
  } out_item_t;

  typedef struct packed {
    logic       enabled;
    logic [5:0] step_index;
    logic [1:0] sub_phase;
    logic [2:0] repeat_count;
    logic [4:0] burst_entry;
    logic [3:0] ramp_step;
    logic [1:0] burst_direction;
    logic [7:0] seed;
  } seq_state_t;

  // fixed table direction repeats forward, stop, reverse, stop
  function automatic logic [1:0] pat_dir(input logic [1:0] idx);
    logic [1:0] d;
    case (idx)
      2'd0:    d = DIR_FWD;
      2'd2:    d = DIR_REV;
      default: d = DIR_STOP;
    endcase
    return d;
  endfunction

  function automatic logic [11:0] pat_ms(input logic [1:0] idx);
    return idx[0] ? 12'd100 : 12'd250;
  endfunction

  function automatic logic [11:0] fix_ms(input logic [5:0] idx);
    logic [11:0] ms;
    case (idx)
      6'd8:                                  ms = 12'd2500;
      6'd16, 6'd20, 6'd22, 6'd24, 6'd26,
      6'd28, 6'd32, 6'd34, 6'd36, 6'd38:     ms = 12'd1000;
      6'd18, 6'd30:                          ms = 12'd1500;
      6'd39:                                 ms = 12'd3000;
      default:                               ms = 12'd500;
    endcase
    return ms;
  endfunction

  function automatic logic [1:0] burst_rom(input logic [4:0] idx);
    logic [1:0] d;
    case (idx)
      5'd2, 5'd3, 5'd5, 5'd7, 5'd8, 5'd9,
      5'd13, 5'd15, 5'd17, 5'd18:            d = DIR_REV;
      default:                               d = DIR_FWD;
    endcase
    return d;
  endfunction

  // result formatting: anything but forward/reverse drives nothing
  function automatic out_item_t make_result(input logic [1:0]  dir,
                                            input logic [6:0]  duty,
                                            input logic [11:0] delay,
                                            input logic        armed);
    out_item_t r;
    logic      drive;
    drive          = (dir == DIR_FWD) || (dir == DIR_REV);
    r.direction    = drive ? dir : DIR_STOP;
    r.duty_pct     = drive ? duty : 7'd0;
    r.delay_ms     = delay;
    r.timer_armed  = armed;
    r.running      = drive && (duty != 7'd0);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/mps_step.sv -----
// ----------------------------------------------------------------------------
// mps_step: sequence step logic
// Computes the next sequence state and the result for one event item.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_step
  import mps_pkg::*;
(
  input  logic       work_mode_i,
  input  logic [6:0] speed_percent_i,
  input  in_item_t   item_i,
  input  seq_state_t state_i,
  output seq_state_t state_o,
  output out_item_t  result_o,
  output logic       has_result_o
);

  seq_state_t  eff;        // state seen by the expiry logic
  seq_state_t  exp_nxt;
  out_item_t   exp_res;

  logic [7:0]  seed_adv;
  logic [20:0] seed_prod;
  logic [12:0] seed_rem;
  logic [4:0]  seed_mod;

  logic [6:0]  speed_sat;
  logic [6:0]  base_duty;
  logic [12:0] mv_clamp;
  logic [9:0]  mv_diff;
  logic [19:0] boost_prod;
  logic [4:0]  boost;
  logic [7:0]  duty_sum;
  logic [6:0]  fixed_duty;

  logic [9:0]  ramp_num;
  logic [26:0] ramp_prod;
  logic [6:0]  ramp_duty;

  logic [5:0]  fix_idx;
  logic [5:0]  si_inc;
  logic [2:0]  rc_inc;
  logic [4:0]  rom_idx;
  logic [4:0]  be_next;
  logic [5:0]  be_inc;

  // seed update and reduction modulo the burst table size
  always_comb begin
    seed_adv  = 8'(state_i.seed * 8'(SEED_MUL) + 8'(SEED_ADD));
    seed_prod = 21'(seed_adv) * 21'(SEED_RECIP);
    seed_rem  = 13'(seed_adv) - 13'(seed_prod[20:SEED_SHIFT] * 13'(BURST_TABLE_SIZE));
    seed_mod  = (seed_rem >= 13'(BURST_TABLE_SIZE)) ?
                5'(seed_rem - 13'(BURST_TABLE_SIZE)) : 5'(seed_rem);
  end

  // fixed mode duty: 50 + speed/2, plus up to 20 when the battery sags unless on external power, capped at 100
  always_comb begin
    speed_sat  = (speed_percent_i > 7'(DUTY_MAX)) ? 7'(DUTY_MAX) : speed_percent_i;
    base_duty  = 7'(DUTY_MIN) + {1'b0, speed_sat[6:1]};
    if (item_i.battery_mv < 13'(VMIN_MV)) begin
      mv_clamp = 13'(VMIN_MV);
    end else if (item_i.battery_mv > 13'(VMAX_MV)) begin
      mv_clamp = 13'(VMAX_MV);
    end else begin
      mv_clamp = item_i.battery_mv;
    end
    mv_diff    = 10'(13'(VMAX_MV) - mv_clamp);
    boost_prod = 20'(mv_diff) * 20'(BOOST_RECIP);
    boost      = 5'(boost_prod >> BOOST_SHIFT);
    duty_sum   = {1'b0, base_duty} + 8'(boost);
    if (item_i.external_power) begin
      fixed_duty = base_duty;
    end else if (duty_sum > 8'(DUTY_MAX)) begin
      fixed_duty = 7'(DUTY_MAX);
    end else begin
      fixed_duty = 7'(duty_sum);
    end
  end

  // burst ramp duty
  always_comb begin
    ramp_num  = 10'(eff.ramp_step * 10'(RAMP_SPAN));
    ramp_prod = 27'(ramp_num) * 27'(RAMP_RECIP);
    if (eff.ramp_step >= 4'(RAMP_MAX)) begin
      ramp_duty = 7'(DUTY_MAX);
    end else begin
      ramp_duty = 7'(RAMP_BASE) + 7'(ramp_prod >> RAMP_SHIFT);
    end
  end

  // start clears the sequence and reseeds before acting as an expiry
  always_comb begin
    eff = state_i;
    if (item_i.kind == KIND_START) begin
      eff.enabled         = 1'b1;
      eff.step_index      = '0;
      eff.sub_phase       = PH_PATTERN;
      eff.repeat_count    = '0;
      eff.ramp_step       = '0;
      eff.burst_direction = DIR_STOP;
      eff.seed            = seed_adv;
      eff.burst_entry     = seed_mod;
    end
  end

  always_comb begin
    fix_idx = (eff.step_index >= 6'(FIX_TABLE_LEN)) ?
              6'(eff.step_index - 6'(FIX_TABLE_LEN)) : eff.step_index;
    si_inc  = eff.step_index + 6'd1;
    rc_inc  = eff.repeat_count + 3'd1;
    rom_idx = (eff.burst_entry >= 5'(BURST_ROM_LEN)) ?
              5'(eff.burst_entry - 5'(BURST_ROM_LEN)) : eff.burst_entry;
    be_inc  = {1'b0, eff.burst_entry} + 6'd1;
    be_next = (be_inc == 6'(BURST_TABLE_SIZE)) ? 5'd0 : be_inc[4:0];
  end

  // expiry handling on the effective state
  always_comb begin
    exp_nxt = eff;
    exp_res = make_result(DIR_STOP, 7'd0, 12'd0, 1'b0);
    if (!eff.enabled) begin
      exp_res = make_result(DIR_STOP, 7'd0, 12'd0, 1'b0);
    end else if (!work_mode_i) begin
      exp_res = make_result(pat_dir(fix_idx[1:0]), fixed_duty, fix_ms(fix_idx), 1'b1);
      exp_nxt.step_index = (7'(si_inc) >= 7'(FIXED_STEPS)) ? 6'd0 : si_inc;
    end else begin
      case (eff.sub_phase)
        PH_PATTERN: begin
          exp_res = make_result(pat_dir(eff.step_index[1:0]), 7'(PAT_DUTY),
                                pat_ms(eff.step_index[1:0]), 1'b1);
          if (si_inc >= 6'(PAT_LEN)) begin
            exp_nxt.step_index = '0;
            if (4'(rc_inc) >= 4'(PATTERN_REPEATS)) begin
              // pattern done: first ramp step follows at once
              exp_nxt.sub_phase       = PH_BURST;
              exp_nxt.repeat_count    = '0;
              exp_nxt.burst_direction = burst_rom(rom_idx);
              exp_nxt.ramp_step       = 4'd1;
              exp_nxt.burst_entry     = be_next;
              exp_res = make_result(burst_rom(rom_idx), 7'(RAMP_BASE),
                                    12'(BURST_STEP_MS), 1'b1);
            end else begin
              exp_nxt.repeat_count = rc_inc;
            end
          end else begin
            exp_nxt.step_index = si_inc;
          end
        end
        PH_BURST: begin
          if (5'(eff.ramp_step) < 5'(RAMP_STEPS)) begin
            exp_res = make_result(eff.burst_direction, ramp_duty,
                                  12'(BURST_STEP_MS), 1'b1);
            exp_nxt.ramp_step = eff.ramp_step + 4'd1;
          end else begin
            exp_nxt.sub_phase = PH_PAUSE;
            exp_res = make_result(DIR_STOP, 7'd0, 12'(PAUSE_MS), 1'b1);
          end
        end
        default: begin
          // pause, and the unused phase code
          exp_nxt.sub_phase  = PH_PATTERN;
          exp_nxt.step_index = 6'd1;
          exp_res = make_result(pat_dir(2'd0), 7'(PAT_DUTY), pat_ms(2'd0), 1'b1);
        end
      endcase
    end
  end

  always_comb begin
    state_o      = state_i;
    result_o     = exp_res;
    has_result_o = 1'b0;
    case (item_i.kind)
      KIND_EXPIRY: begin
        state_o      = exp_nxt;
        has_result_o = 1'b1;
      end
      KIND_START: begin
        if (!state_i.enabled) begin
          state_o      = exp_nxt;
          has_result_o = 1'b1;
        end
      end
      KIND_STOP: begin
        state_o.enabled = 1'b0;
        result_o        = make_result(DIR_STOP, 7'd0, 12'd0, 1'b0);
        has_result_o    = 1'b1;
      end
      default: begin
        has_result_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/motor_pattern_sequencer_top.sv -----
// An accepted item waits in the input register; its result is held in the result register.
// Throughput: one item per cycle while results are taken; the input register frees whenever its item
//   moves on, and the result register is refilled as its item is taken.
// Start requests while running and unused event codes leave no result.
// Reset: asynchronous, active low; clears sequence state, speed goes to 50.
// ----------------------------------------------------------------------------
// motor_pattern_sequencer_top: motor pattern sequencer
// Event items in, drive direction/duty/delay items out, two config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_pattern_sequencer_top
  import mps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       work_mode_q;
  logic [6:0] speed_q;
  seq_state_t state_q;

  seq_state_t state_d;
  out_item_t  result;
  logic       has_result;
  logic       advance;

  mps_step u_step (
    .work_mode_i     (work_mode_q),
    .speed_percent_i (speed_q),
    .item_i          (in_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result),
    .has_result_o    (has_result)
  );

  // item leaves the input register unless its result has nowhere to go
  assign advance     = in_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_mode_q <= 1'b0;
      speed_q     <= 7'(SPEED_RESET);
      state_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WORK_MODE: begin
          work_mode_q             <= cfg_data_i[0];
          state_q.step_index      <= '0;
          state_q.sub_phase       <= PH_PATTERN;
          state_q.repeat_count    <= '0;
          state_q.ramp_step       <= '0;
          state_q.burst_direction <= DIR_STOP;
        end
        REG_SPEED: begin
          speed_q <= cfg_data_i;
        end
        default: begin
          speed_q <= speed_q;
        end
      endcase
    end else if (advance) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/mps_checker.sv -----
// ----------------------------------------------------------------------------
// mps_checker: port-level checks for the motor pattern sequencer
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_checker
  import mps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  a_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.running ==
      ((out_data_o.direction != DIR_STOP) && (out_data_o.duty_pct != 7'd0)))
    else $error("running flag disagrees with direction and duty");

  a_unarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.timer_armed |->
      out_data_o.direction == DIR_STOP && out_data_o.delay_ms == 12'd0)
    else $error("unarmed result drives motor or carries delay");

  a_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.direction == DIR_STOP |-> out_data_o.duty_pct == 7'd0)
    else $error("stopped result with nonzero duty");

endmodule

bind motor_pattern_sequencer_top mps_checker u_mps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- bench/tb_motor_pattern_sequencer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_pattern_sequencer_top: self-checking bench for the motor sequencer
// Opens with a table of directed events and register writes. A long randomized
// run of start/expiry/stop sequences in both modes follows. Every result is
// compared field by field against an in-bench model of the sequencer or a typed value.
// ----------------------------------------------------------------------------

module tb_motor_pattern_sequencer_top;
  import mps_pkg::*;

  localparam int CLK_PERIOD_NS = 12;
  localparam int RUN_LIMIT_NS  = 6_000_000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_EVENTS = 1250;

  // sequencer sizing and timing, as specified for the block
  localparam int unsigned SEQ_FIXED_STEPS   = 40;
  localparam int unsigned SEQ_BURST_ENTRIES = 20;
  localparam int unsigned SEQ_REPEATS       = 5;
  localparam int unsigned SEQ_RAMP_STEPS    = 12;
  localparam int unsigned FIXED_LEN         = 40;
  localparam int unsigned BURST_LEN         = 20;
  localparam int unsigned PATTERN_LEN       = 4;
  localparam int unsigned PATTERN_DUTY      = 70;
  localparam int unsigned PAUSE_HOLD_MS     = 2000;
  localparam int unsigned RAMP_HOLD_MS      = 6000 / SEQ_RAMP_STEPS;
  localparam int unsigned BATT_FLOOR_MV     = 3500;
  localparam int unsigned BATT_CEIL_MV      = 4200;
  localparam int unsigned BOOST_LIMIT       = 20;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  // fixed table direction repeats the pattern directions
  localparam dir_e PAT_DIR [4] = '{DIR_FWD, DIR_STOP, DIR_REV, DIR_STOP};
  localparam int unsigned PAT_HOLD_MS [4] = '{250, 100, 250, 100};
  localparam int unsigned FIXED_HOLD_MS [40] = '{
    500, 500, 500, 500, 500, 500, 500, 500, 2500, 500,
    500, 500, 500, 500, 500, 500, 1000, 500, 1500, 500,
    1000, 500, 1000, 500, 1000, 500, 1000, 500, 1000, 500,
    1500, 500, 1000, 500, 1000, 500, 1000, 500, 1000, 3000};
  localparam dir_e BURST_DIR [20] = '{
    DIR_FWD, DIR_FWD, DIR_REV, DIR_REV, DIR_FWD, DIR_REV, DIR_FWD, DIR_REV,
    DIR_REV, DIR_REV, DIR_FWD, DIR_FWD, DIR_FWD, DIR_REV, DIR_FWD, DIR_REV,
    DIR_FWD, DIR_REV, DIR_REV, DIR_FWD};

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_op_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_e;

  typedef struct packed {
    row_op_e     op;
    logic [1:0]  kind;
    logic        ext;
    logic [12:0] mv;
    logic [1:0]  reg_idx;
    logic [6:0]  reg_val;
    chk_e        chk;
    out_item_t   typed;
  } plan_row_t;

  localparam out_item_t HALTED = '{direction: DIR_STOP, duty_pct: 7'd0,
                                   delay_ms: 12'd0, timer_armed: 1'b0, running: 1'b0};
  localparam out_item_t FIRST_FIXED = '{direction: DIR_FWD, duty_pct: 7'd75,
                                        delay_ms: 12'd500, timer_armed: 1'b1,
                                        running: 1'b1};

  localparam int OPENING_ROWS = 27;
  localparam plan_row_t OPENING [27] = '{
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, HALTED},
    '{ROW_EVENT, KIND_STOP,   1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, HALTED},
    '{ROW_EVENT, KIND_UNUSED, 1'b1, 13'd8191, REG_WORK_MODE, 7'd0, CHK_NONE,  HALTED},
    '{ROW_EVENT, KIND_START,  1'b1, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, FIRST_FIXED},
    '{ROW_EVENT, KIND_START,  1'b0, 13'd3800, REG_WORK_MODE, 7'd0, CHK_NONE,  HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd0,    REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd8191, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_SPEED,     7'd100, CHK_NONE, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd3500, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd3500, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_SPEED,     7'd127, CHK_NONE, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b1, 13'd4200, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b1, 13'd0,    REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_SPEED,     7'd0, CHK_NONE,  HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd4200, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd3850, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_STOP,   1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b1, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_WORK_MODE, 7'd1, CHK_NONE,  HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_SPARE,     7'h7F, CHK_NONE, HALTED},
    '{ROW_EVENT, KIND_START,  1'b0, 13'd3600, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b1, 13'd4000, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_UNUSED, 1'b0, 13'd0,    REG_WORK_MODE, 7'd0, CHK_NONE,  HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_WRITE, KIND_EXPIRY, 1'b0, 13'd0,    REG_WORK_MODE, 7'd0, CHK_NONE,  HALTED},
    '{ROW_EVENT, KIND_EXPIRY, 1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_MODEL, HALTED},
    '{ROW_EVENT, KIND_STOP,   1'b0, 13'd4000, REG_WORK_MODE, 7'd0, CHK_TYPED, HALTED}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       ev_valid  = 1'b0;
  logic       ev_ready;
  in_item_t   ev_data   = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  out_item_t  res_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data  = '0;

  // model copy of the sequencer state and registers
  logic       mode_q   = 1'b0;
  logic [6:0] speed_q  = 7'd50;
  logic       en_q     = 1'b0;
  logic [5:0] step_q   = '0;
  logic [1:0] phase_q  = PH_PATTERN;
  logic [2:0] rep_q    = '0;
  logic [4:0] entry_q  = '0;
  logic [3:0] ramp_q   = '0;
  logic [1:0] bdir_q   = DIR_STOP;
  logic [7:0] seed_q   = '0;

  out_item_t owed_drive [$];
  int        faults       = 0;
  int        burst_left   = 0;
  int        events_to_go = 0;
  int        ready_tick   = 0;
  int        stall_style  = 0;

  motor_pattern_sequencer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_ready_o  (ev_ready),
    .in_data_i   (ev_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD_NS / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_motor_pattern_sequencer_top NOT OK");
    $finish;
  end

  function automatic out_item_t drive_result(input logic [1:0] dir, input int unsigned duty,
                                             input int unsigned delay, input logic armed);
    out_item_t r;
    r = '0;
    if (dir == DIR_FWD || dir == DIR_REV) begin
      r.direction = dir;
      r.duty_pct  = 7'(duty);
    end
    r.delay_ms    = 12'(delay);
    r.timer_armed = armed;
    r.running     = (r.direction != DIR_STOP) && (r.duty_pct != 7'd0);
    return r;
  endfunction

  // speed maps onto 50..100, low battery adds up to 20 unless on external power
  function automatic int unsigned boosted_duty(input logic ext, input logic [12:0] mv);
    int unsigned pct, base, v, d;
    pct  = (speed_q > 7'd100) ? 100 : speed_q;
    base = 50 + (pct * 50) / 100;
    if (ext) return base;
    v = mv;
    if (v < BATT_FLOOR_MV) v = BATT_FLOOR_MV;
    if (v > BATT_CEIL_MV) v = BATT_CEIL_MV;
    d = base + ((BATT_CEIL_MV - v) * BOOST_LIMIT) / (BATT_CEIL_MV - BATT_FLOOR_MV);
    return (d > 100) ? 100 : d;
  endfunction

  task automatic ramp_result(output out_item_t r);
    int unsigned duty;
    if (ramp_q >= SEQ_RAMP_STEPS - 1) duty = 100;
    else duty = 60 + (40 * ramp_q) / (SEQ_RAMP_STEPS - 1);
    r = drive_result(bdir_q, duty, RAMP_HOLD_MS, 1'b1);
    ramp_q = ramp_q + 4'd1;
  endtask

  task automatic run_expiry(input logic ext, input logic [12:0] mv, output out_item_t r);
    int unsigned i;
    if (!en_q) begin
      r = drive_result(DIR_STOP, 0, 0, 1'b0);
    end else if (!mode_q) begin
      i = step_q % FIXED_LEN;
      r = drive_result(PAT_DIR[i % PATTERN_LEN], boosted_duty(ext, mv), FIXED_HOLD_MS[i], 1'b1);
      step_q = step_q + 6'd1;
      if (step_q >= SEQ_FIXED_STEPS) step_q = '0;
    end else if (phase_q == PH_PATTERN) begin
      i = step_q % PATTERN_LEN;
      r = drive_result(PAT_DIR[i], PATTERN_DUTY, PAT_HOLD_MS[i], 1'b1);
      step_q = step_q + 6'd1;
      if (step_q >= PATTERN_LEN) begin
        step_q = '0;
        rep_q  = rep_q + 3'd1;
        // last pattern round rolls straight into the first burst step
        if (rep_q >= SEQ_REPEATS) begin
          phase_q = PH_BURST;
          rep_q   = '0;
          bdir_q  = BURST_DIR[entry_q % BURST_LEN];
          ramp_q  = '0;
          ramp_result(r);
          entry_q = 5'((entry_q + 1) % SEQ_BURST_ENTRIES);
        end
      end
    end else if (phase_q == PH_BURST) begin
      if (ramp_q < SEQ_RAMP_STEPS) begin
        ramp_result(r);
      end else begin
        phase_q = PH_PAUSE;
        r = drive_result(DIR_STOP, 0, PAUSE_HOLD_MS, 1'b1);
      end
    end else begin
      phase_q = PH_PATTERN;
      r = drive_result(PAT_DIR[0], PATTERN_DUTY, PAT_HOLD_MS[0], 1'b1);
      step_q = 6'd1;
    end
  endtask

  task automatic advance_sequencer(input in_item_t it, output bit made, output out_item_t r);
    made = 1'b1;
    r    = HALTED;
    case (it.kind)
      KIND_EXPIRY: run_expiry(it.external_power, it.battery_mv, r);
      KIND_START: begin
        if (en_q) begin
          made = 1'b0;
        end else begin
          en_q    = 1'b1;
          step_q  = '0;
          phase_q = PH_PATTERN;
          rep_q   = '0;
          ramp_q  = '0;
          bdir_q  = DIR_STOP;
          seed_q  = 8'((seed_q * 13) + 7);
          entry_q = 5'(seed_q % SEQ_BURST_ENTRIES);
          run_expiry(it.external_power, it.battery_mv, r);
        end
      end
      KIND_STOP: begin
        en_q = 1'b0;
        r    = drive_result(DIR_STOP, 0, 0, 1'b0);
      end
      default: made = 1'b0;
    endcase
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [6:0] val);
    if (idx == REG_WORK_MODE) begin
      mode_q  = val[0];
      step_q  = '0;
      phase_q = PH_PATTERN;
      rep_q   = '0;
      ramp_q  = '0;
      bdir_q  = DIR_STOP;
    end else if (idx == REG_SPEED) begin
      speed_q = val;
    end
  endtask

  // drop valid, wait out every owed result plus items that leave none
  task automatic settle();
    ev_valid <= 1'b0;
    while (owed_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_event(input in_item_t it, input chk_e chk, input out_item_t typed);
    int unsigned gap;
    bit          made;
    out_item_t   r;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    ev_valid <= 1'b1;
    ev_data  <= it;
    do @(posedge clk); while (!ev_ready);
    burst_left--;
    advance_sequencer(it, made, r);
    if (made) events_to_go--;
    case (chk)
      CHK_MODEL: if (made) owed_drive.push_back(r);
      CHK_TYPED: owed_drive.push_back(typed);
      default: ;
    endcase
  endtask

  function automatic in_item_t make_event(input logic [1:0] kind);
    in_item_t    it;
    int unsigned sel;
    it.kind           = kind;
    it.external_power = ($urandom_range(0, 2) == 0);
    sel = $urandom_range(0, 9);
    if (sel < 7) it.battery_mv = 13'($urandom_range(3400, 4300));
    else if (sel < 9) it.battery_mv = 13'($urandom_range(0, 8191));
    else it.battery_mv = $urandom_range(0, 1) ? 13'(BATT_FLOOR_MV) : 13'(BATT_CEIL_MV);
    return it;
  endfunction

  function automatic logic [6:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd101;
      3: return 7'h7F;
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic match_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && res_valid && res_ready) begin
      if (owed_drive.size() == 0) begin
        $display("%0t: result expected none got %h", $time, res_data);
        faults++;
      end else begin
        want = owed_drive.pop_front();
        match_field("direction", want.direction, res_data.direction);
        match_field("duty_pct", want.duty_pct, res_data.duty_pct);
        match_field("delay_ms", want.delay_ms, res_data.delay_ms);
        match_field("timer_armed", want.timer_armed, res_data.timer_armed);
        match_field("running", want.running, res_data.running);
      end
    end
    ready_tick++;
    if (ready_tick % 256 == 0) stall_style = $urandom_range(0, 2);
    case (stall_style)
      0: res_ready <= 1'b1;
      1: res_ready <= ($urandom_range(0, 3) != 0);
      default: res_ready <= (ready_tick % 6 == 0);
    endcase
  end

  initial begin
    in_item_t    it;
    int unsigned run;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < OPENING_ROWS; n++) begin
      if (OPENING[n].op == ROW_WRITE) begin
        write_reg(OPENING[n].reg_idx, OPENING[n].reg_val);
      end else begin
        it                = '0;
        it.kind           = OPENING[n].kind;
        it.external_power = OPENING[n].ext;
        it.battery_mv     = OPENING[n].mv;
        send_event(it, OPENING[n].chk, OPENING[n].typed);
      end
    end

    // random phases: mostly start then long expiry runs, with noise mixed in
    events_to_go = RANDOM_EVENTS;
    while (events_to_go > 0) begin
      if ($urandom_range(0, 1)) write_reg(REG_WORK_MODE, 7'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(REG_SPEED, pick_speed());
      if ($urandom_range(0, 7) != 0) send_event(make_event(KIND_START), CHK_MODEL, HALTED);
      run = $urandom_range(1, 90);
      repeat (run) begin
        if ($urandom_range(0, 11) == 0)
          send_event(make_event(2'($urandom_range(0, 3))), CHK_MODEL, HALTED);
        else
          send_event(make_event(KIND_EXPIRY), CHK_MODEL, HALTED);
        if ($urandom_range(0, 149) == 0) settle();
      end
      if ($urandom_range(0, 1)) send_event(make_event(KIND_STOP), CHK_MODEL, HALTED);
    end

    settle();
    if (faults == 0) begin
      $display("tb_motor_pattern_sequencer_top OK");
    end else begin
      $display("tb_motor_pattern_sequencer_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mps_pkg.sv
src/mps_step.sv
src/motor_pattern_sequencer_top.sv
src/mps_checker.sv
bench/tb_motor_pattern_sequencer_top.sv
